[rtl/rnsm_pkg.sv]
package rnsm_pkg;

    localparam int          CNT_BITS_DEF = 16;
    localparam logic [31:0] EPS_RST      = 32'h3727C5AC;
    localparam logic [31:0] ONE_BITS     = 32'h3F800000;
    localparam logic [31:0] DEF_NAN      = 32'hFFC00000;
    localparam logic [31:0] SQRT_NAN     = 32'h7FC00000;
    localparam logic [31:0] QUIET_BIT    = 32'h00400000;

    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_DIV  = 3'd2;
    localparam logic [2:0] OP_SQRT = 3'd3;
    localparam logic [2:0] OP_CVT  = 3'd4;

    localparam logic [1:0] K_ACC       = 2'd0;
    localparam logic [1:0] K_ACC_END   = 2'd1;
    localparam logic [1:0] K_APPLY     = 2'd2;
    localparam logic [1:0] K_APPLY_END = 2'd3;

    typedef logic signed [10:0] t_exp;

    typedef struct packed {
        logic        sign;
        t_exp        exp;
        logic [23:0] mant;
    } t_unp;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [31:0] weight;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_fq;

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } t_res;

    typedef struct packed {
        logic        start;
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_fpu_rsp;

    function automatic logic [5:0] f_lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic       hit;
        n   = '0;
        hit = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!hit) begin
                if (v[i]) begin
                    hit = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

    // normalized significand, subnormals shifted up
    function automatic t_unp f_unpack(input logic [31:0] x);
        t_unp       u;
        logic [5:0] lz;
        lz     = '0;
        u.sign = x[31];
        if (x[30:23] != 8'd0) begin
            u.exp  = t_exp'({3'b0, x[30:23]});
            u.mant = {1'b1, x[22:0]};
        end else begin
            lz     = f_lzc32({1'b0, x[22:0], 8'd0});
            u.mant = {1'b0, x[22:0]} << lz;
            u.exp  = 11'sd1 - t_exp'({5'b0, lz});
        end
        return u;
    endfunction

    // sig: hidden bit, 23 fraction bits, round bit, sticky bit
    function automatic logic [31:0] f_round(input logic sign, input t_exp exp,
                                            input logic [25:0] sig);
        logic [10:0] shn;
        logic [4:0]  sh;
        logic [25:0] d;
        logic [30:0] base;
        logic        up;
        if (exp >= 11'sd255) begin
            return {sign, 8'hFF, 23'd0};
        end
        if (exp <= 11'sd0) begin
            shn  = 11'(11'sd1 - exp);
            sh   = (shn > 11'd26) ? 5'd26 : shn[4:0];
            d    = sig >> sh;
            d[0] = d[0] | (|(sig & ((26'd1 << sh) - 26'd1)));
            base = {8'd0, d[24:2]};
        end else begin
            d    = sig;
            base = {exp[7:0], sig[24:2]};
        end
        up = d[1] & (d[0] | d[2]);
        return {sign, base + 31'(up)};
    endfunction

endpackage

[rtl/rms_norm_scale_multiply.sv]
// float32 rms normalization with elementwise weight. cmd 0 items square the value and add it to
// a running sum in arrival order; the item marked row end then forms 1/sqrt(sum/count + eps)
// as the row scale and clears the sum and count. cmd 1 items return (value * scale) * weight
// with the row-end mark echoed. all operations round to nearest even with full subnormal
// support. a two-entry input queue and a two-entry result queue decouple both sides from the
// single shared floating-point unit, which runs one operation at a time. the row-end item
// then uses the one-bit-per-cycle divider and square root (25 steps each) of that unit.
module rms_norm_scale_multiply import rnsm_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_value_bits,
    input  logic [31:0] i_weight_bits,
    input  logic        i_row_end,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result_bits,
    output logic        o_result_end,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    t_fq  fq;
    logic take;

    rnsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_value_bits  (i_value_bits),
        .i_weight_bits (i_weight_bits),
        .i_row_end     (i_row_end),
        .o_fq          (fq),
        .i_take        (take)
    );

    rnsm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fq          (fq),
        .o_take        (take),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .empty         (empty),
        .pop           (pop),
        .o_result_bits (o_result_bits),
        .o_result_end  (o_result_end)
    );

endmodule

[rtl/rnsm_front.sv]
module rnsm_front import rnsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_value_bits,
    input  logic [31:0] i_weight_bits,
    input  logic        i_row_end,
    output t_fq         o_fq,
    input  logic        i_take
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;
    t_item      cls;

    // classify by command and row mark
    always_comb begin
        cls.value  = i_value_bits;
        cls.weight = i_weight_bits;
        case ({i_cmd, i_row_end})
            2'b00:   cls.kind = K_ACC;
            2'b01:   cls.kind = K_ACC_END;
            2'b10:   cls.kind = K_APPLY;
            default: cls.kind = K_APPLY_END;
        endcase
    end

    assign full       = (r_cnt == 2'd2);
    assign wr         = push && !full;
    assign rd         = i_take && (r_cnt != 2'd0);
    assign o_fq.valid = (r_cnt != 2'd0);
    assign o_fq.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

[rtl/rnsm_fpu.sv]
module rnsm_fpu import rnsm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fpu_req i_req,
    output t_fpu_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_NORM = 3'd4;
    localparam logic [2:0] S_RND  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  r_st, n_st;
    logic [2:0]  r_op, n_op;
    logic [31:0] r_a, n_a, r_b, n_b, r_res, n_res;
    logic        r_sign, n_sign;
    t_exp        r_exp, n_exp;
    logic [23:0] r_ma, n_ma, r_mb, n_mb;
    logic [47:0] r_prod, n_prod;
    logic [27:0] r_sum, n_sum;
    logic [25:0] r_sig, n_sig;
    logic [27:0] r_rem, n_rem;
    logic [24:0] r_q, n_q;
    logic [49:0] r_rad, n_rad;
    logic [4:0]  r_cnt, n_cnt;

    t_unp        ua, ub;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
    logic        ge;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, diff;
    logic [26:0] mbx, msx, msh;
    logic [27:0] add_sum;
    logic [5:0]  lzv, lzs;
    logic [31:0] nv;
    logic [26:0] n27;
    t_exp        eu;
    logic [24:0] m25, d25, dt;
    logic [27:0] rn, tr;

    assign ua     = f_unpack(r_a);
    assign ub     = f_unpack(r_b);
    assign a_nan  = (&r_a[30:23]) && (|r_a[22:0]);
    assign b_nan  = (&r_b[30:23]) && (|r_b[22:0]);
    assign a_inf  = (&r_a[30:23]) && !(|r_a[22:0]);
    assign b_inf  = (&r_b[30:23]) && !(|r_b[22:0]);
    assign a_zero = (r_a[30:0] == 31'd0);
    assign b_zero = (r_b[30:0] == 31'd0);
    assign sx     = r_a[31] ^ r_b[31];

    // add alignment
    assign ge   = (r_a[30:0] >= r_b[30:0]);
    assign big  = ge ? r_a : r_b;
    assign sml  = ge ? r_b : r_a;
    assign eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    assign es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    assign diff = eb - es;
    assign mbx  = {big[30:23] != 8'd0, big[22:0], 3'b0};
    assign msx  = {sml[30:23] != 8'd0, sml[22:0], 3'b0};

    always_comb begin
        if (diff >= 8'd27) begin
            msh = {26'd0, |msx};
        end else begin
            msh = (msx >> diff[4:0])
                | {26'd0, |(msx & ((27'd1 << diff[4:0]) - 27'd1))};
        end
    end

    assign add_sum = (big[31] == sml[31]) ? ({1'b0, mbx} + {1'b0, msh})
                                          : ({1'b0, mbx} - {1'b0, msh});

    // integer to float
    assign lzv = f_lzc32(r_a);
    assign nv  = r_a << lzv;

    // sum normalize
    assign lzs = f_lzc32({r_sum, 4'd0});
    always_comb begin
        if (r_sum[27]) begin
            n27 = {r_sum[27:2], r_sum[1] | r_sum[0]};
        end else begin
            n27 = r_sum[26:0] << (lzs - 6'd1);
        end
    end

    // sqrt exponent parity
    always_comb begin
        eu  = ua.exp - 11'sd127;
        m25 = {1'b0, ua.mant};
        if (eu[0]) begin
            m25 = {ua.mant, 1'b0};
            eu  = eu - 11'sd1;
        end
    end

    // iteration steps
    assign d25 = r_rem[24:0];
    assign dt  = d25 - {1'b0, r_mb};
    assign rn  = {r_rem[25:0], r_rad[49:48]};
    assign tr  = {1'b0, r_q, 2'b01};

    always_comb begin
        n_st   = r_st;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_res  = r_res;
        n_sign = r_sign;
        n_exp  = r_exp;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_prod = r_prod;
        n_sum  = r_sum;
        n_sig  = r_sig;
        n_rem  = r_rem;
        n_q    = r_q;
        n_rad  = r_rad;
        n_cnt  = r_cnt;
        case (r_st)
            S_IDLE: begin
                if (i_req.start) begin
                    n_op = i_req.op;
                    n_a  = i_req.a;
                    n_b  = i_req.b;
                    n_st = S_PREP;
                end
            end
            S_PREP: begin
                n_st = S_DONE;
                case (r_op)
                    OP_MUL: begin
                        if (a_nan) begin
                            n_res = r_a | QUIET_BIT;
                        end else if (b_nan) begin
                            n_res = r_b | QUIET_BIT;
                        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                            n_res = DEF_NAN;
                        end else if (a_inf || b_inf) begin
                            n_res = {sx, 8'hFF, 23'd0};
                        end else if (a_zero || b_zero) begin
                            n_res = {sx, 31'd0};
                        end else begin
                            n_sign = sx;
                            n_ma   = ua.mant;
                            n_mb   = ub.mant;
                            n_exp  = ua.exp + ub.exp - 11'sd127;
                            n_st   = S_MUL;
                        end
                    end
                    OP_ADD: begin
                        if (a_nan) begin
                            n_res = r_a | QUIET_BIT;
                        end else if (b_nan) begin
                            n_res = r_b | QUIET_BIT;
                        end else if (a_inf && b_inf && sx) begin
                            n_res = DEF_NAN;
                        end else if (a_inf) begin
                            n_res = r_a;
                        end else if (b_inf) begin
                            n_res = r_b;
                        end else if (add_sum == 28'd0) begin
                            n_res = {r_a[31] & r_b[31], 31'd0};
                        end else begin
                            n_sign = big[31];
                            n_sum  = add_sum;
                            n_exp  = t_exp'({3'b0, eb});
                            n_st   = S_NORM;
                        end
                    end
                    OP_DIV: begin
                        if (a_nan) begin
                            n_res = r_a | QUIET_BIT;
                        end else if (b_nan) begin
                            n_res = r_b | QUIET_BIT;
                        end else if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                            n_res = DEF_NAN;
                        end else if (a_inf || b_zero) begin
                            n_res = {sx, 8'hFF, 23'd0};
                        end else if (a_zero || b_inf) begin
                            n_res = {sx, 31'd0};
                        end else begin
                            n_sign = sx;
                            n_mb   = ub.mant;
                            n_q    = '0;
                            n_cnt  = 5'd25;
                            n_st   = S_ITER;
                            if (ua.mant < ub.mant) begin
                                n_rem = {3'd0, ua.mant, 1'b0};
                                n_exp = ua.exp - ub.exp + 11'sd126;
                            end else begin
                                n_rem = {4'd0, ua.mant};
                                n_exp = ua.exp - ub.exp + 11'sd127;
                            end
                        end
                    end
                    OP_SQRT: begin
                        if (a_nan) begin
                            n_res = r_a | QUIET_BIT;
                        end else if (a_zero) begin
                            n_res = r_a;
                        end else if (r_a[31]) begin
                            n_res = SQRT_NAN;
                        end else if (a_inf) begin
                            n_res = r_a;
                        end else begin
                            n_sign = 1'b0;
                            n_rad  = {m25, 25'd0};
                            n_rem  = '0;
                            n_q    = '0;
                            n_cnt  = 5'd25;
                            n_exp  = (eu >>> 1) + 11'sd127;
                            n_st   = S_ITER;
                        end
                    end
                    OP_CVT: begin
                        n_sign = 1'b0;
                        n_exp  = t_exp'(11'd158 - {5'd0, lzv});
                        n_sig  = {nv[31:7], |nv[6:0]};
                        n_st   = S_RND;
                    end
                    default: begin
                        n_res = DEF_NAN;
                    end
                endcase
            end
            S_MUL: begin
                n_prod = r_ma * r_mb;
                n_st   = S_NORM;
            end
            S_ITER: begin
                if (r_op == OP_DIV) begin
                    if (d25 >= {1'b0, r_mb}) begin
                        n_rem = {3'd0, dt[23:0], 1'b0};
                        n_q   = {r_q[23:0], 1'b1};
                    end else begin
                        n_rem = {3'd0, d25[23:0], 1'b0};
                        n_q   = {r_q[23:0], 1'b0};
                    end
                end else begin
                    if (rn >= tr) begin
                        n_rem = rn - tr;
                        n_q   = {r_q[23:0], 1'b1};
                    end else begin
                        n_rem = rn;
                        n_q   = {r_q[23:0], 1'b0};
                    end
                    n_rad = {r_rad[47:0], 2'b00};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_st = S_NORM;
                end
            end
            S_NORM: begin
                n_st = S_RND;
                case (r_op)
                    OP_MUL: begin
                        if (r_prod[47]) begin
                            n_sig = {r_prod[47:23], |r_prod[22:0]};
                            n_exp = r_exp + 11'sd1;
                        end else begin
                            n_sig = {r_prod[46:22], |r_prod[21:0]};
                        end
                    end
                    OP_ADD: begin
                        n_sig = {n27[26:2], |n27[1:0]};
                        n_exp = r_exp + 11'sd1 - t_exp'({5'd0, lzs});
                    end
                    OP_DIV: begin
                        n_sig = {r_q, r_rem[24:0] != 25'd0};
                    end
                    default: begin
                        n_sig = {r_q, r_rem != 28'd0};
                    end
                endcase
            end
            S_RND: begin
                n_res = f_round(r_sign, r_exp, r_sig);
                n_st  = S_DONE;
            end
            S_DONE: begin
                n_st = S_IDLE;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    assign o_rsp.done = (r_st == S_DONE);
    assign o_rsp.res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_res  <= n_res;
        r_sign <= n_sign;
        r_exp  <= n_exp;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_sig  <= n_sig;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_rad  <= n_rad;
        r_cnt  <= n_cnt;
    end

endmodule

[rtl/rnsm_back.sv]
module rnsm_back import rnsm_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fq         i_fq,
    output logic        o_take,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result_bits,
    output logic        o_result_end
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_SQ   = 4'd1;
    localparam logic [3:0] B_ACC  = 4'd2;
    localparam logic [3:0] B_CVT  = 4'd3;
    localparam logic [3:0] B_MEAN = 4'd4;
    localparam logic [3:0] B_EPS  = 4'd5;
    localparam logic [3:0] B_SQRT = 4'd6;
    localparam logic [3:0] B_RCP  = 4'd7;
    localparam logic [3:0] B_P    = 4'd8;
    localparam logic [3:0] B_Q    = 4'd9;

    logic [3:0]            r_st;
    logic                  r_wait;
    logic [31:0]           r_x, r_w, r_tmp, r_tmp2;
    logic                  r_last;
    logic [31:0]           r_sum, r_scale, r_eps;
    logic [COUNT_BITS-1:0] r_cnt;

    t_res                  r_ob [2];
    logic                  r_owp, r_orp;
    logic [1:0]            r_ocnt;

    t_fpu_req              req;
    t_fpu_rsp              rsp;
    logic                  is_apply, is_last, opush, opop;

    rnsm_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign is_apply = (i_fq.item.kind == K_APPLY) || (i_fq.item.kind == K_APPLY_END);
    assign is_last  = (i_fq.item.kind == K_ACC_END) || (i_fq.item.kind == K_APPLY_END);
    assign o_take   = (r_st == B_IDLE) && i_fq.valid && (!is_apply || r_ocnt != 2'd2);

    always_comb begin
        req.start = (r_st != B_IDLE) && !r_wait;
        req.op    = OP_MUL;
        req.a     = r_x;
        req.b     = r_x;
        case (r_st)
            B_SQ: begin
                req.op = OP_MUL;
            end
            B_ACC: begin
                req.op = OP_ADD;
                req.a  = r_sum;
                req.b  = r_tmp;
            end
            B_CVT: begin
                req.op = OP_CVT;
                req.a  = 32'(r_cnt);
            end
            B_MEAN: begin
                req.op = OP_DIV;
                req.a  = r_tmp;
                req.b  = r_tmp2;
            end
            B_EPS: begin
                req.op = OP_ADD;
                req.a  = r_tmp;
                req.b  = r_eps;
            end
            B_SQRT: begin
                req.op = OP_SQRT;
                req.a  = r_tmp;
            end
            B_RCP: begin
                req.op = OP_DIV;
                req.a  = ONE_BITS;
                req.b  = r_tmp;
            end
            B_P: begin
                req.op = OP_MUL;
                req.b  = r_scale;
            end
            B_Q: begin
                req.op = OP_MUL;
                req.a  = r_tmp;
                req.b  = r_w;
            end
            default: begin
                req.op = OP_MUL;
            end
        endcase
    end

    assign opush = (r_st == B_Q) && rsp.done;
    assign opop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_IDLE;
            r_wait  <= 1'b0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_scale <= ONE_BITS;
            r_eps   <= EPS_RST;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_data;
            end
            if (req.start) begin
                r_wait <= 1'b1;
            end
            if (o_take) begin
                r_st <= is_apply ? B_P : B_SQ;
            end
            if (rsp.done) begin
                r_wait <= 1'b0;
                case (r_st)
                    B_SQ: begin
                        r_st <= B_ACC;
                    end
                    B_ACC: begin
                        r_sum <= rsp.res;
                        if (r_cnt != '1) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_st <= r_last ? B_CVT : B_IDLE;
                    end
                    B_CVT: begin
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_st  <= B_MEAN;
                    end
                    B_MEAN: begin
                        r_st <= B_EPS;
                    end
                    B_EPS: begin
                        r_st <= B_SQRT;
                    end
                    B_SQRT: begin
                        r_st <= B_RCP;
                    end
                    B_RCP: begin
                        r_scale <= rsp.res;
                        r_st    <= B_IDLE;
                    end
                    B_P: begin
                        r_st <= B_Q;
                    end
                    default: begin
                        r_st <= B_IDLE;
                    end
                endcase
            end
            if (opush) begin
                r_owp <= ~r_owp;
            end
            if (opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(opush) - 2'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_x    <= i_fq.item.value;
            r_w    <= i_fq.item.weight;
            r_last <= is_last;
        end
        if (rsp.done) begin
            if (r_st == B_CVT) begin
                r_tmp2 <= rsp.res;
            end else begin
                r_tmp <= rsp.res;
            end
        end
        if (opush) begin
            r_ob[r_owp] <= '{bits: rsp.res, last: r_last};
        end
    end

    assign empty         = (r_ocnt == 2'd0);
    assign o_result_bits = r_ob[r_orp].bits;
    assign o_result_end  = r_ob[r_orp].last;

endmodule

[tb/rnsm_result_checker.sv]
module rnsm_result_checker import rnsm_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_value_bits,
    input  logic [31:0] i_weight_bits,
    input  logic        i_row_end,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] i_result_bits,
    input  logic        i_result_end,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_items,
    output int          o_results,
    output int          o_rows
);

    localparam logic [31:0] POS_INF = 32'h7F800000;

    logic [31:0]           eps;
    logic [31:0]           sum_sq;
    logic [COUNT_BITS-1:0] n_elems;
    logic [31:0]           scale;
    t_res                  want_q[$];

    function automatic bit is_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf(input logic [31:0] x);
        return x[30:0] == POS_INF[30:0];
    endfunction

    function automatic bit is_zero(input logic [31:0] x);
        return x[30:0] == 0;
    endfunction

    // value = m * 2^e
    function automatic void fp_unpack(input logic [31:0] x, output logic [127:0] m,
                                      output int e);
        if (x[30:23] != 0) begin
            m = 128'(x[22:0]) | (128'd1 << 23);
            e = int'(x[30:23]) - 150;
        end else begin
            m = 128'(x[22:0]);
            e = -149;
        end
    endfunction

    // round m * 2^e to float32, nearest even
    function automatic logic [31:0] fp_pack(input bit sgn, input int e, input logic [127:0] m);
        int           p;
        int           sh;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        longint       bits;
        if (m == 0) return {sgn, 31'd0};
        p = 127;
        while (!m[p]) p--;
        sh = p - 23;
        if (-149 - e > sh) sh = -149 - e;
        if (sh > p + 1 || sh > 127) begin
            q = 0;
        end else if (sh > 0) begin
            q    = m >> sh;
            rem  = m & ((128'd1 << sh) - 1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
        end else begin
            q = m << (-sh);
        end
        bits = (longint'(e + sh + 149) <<< 23) + longint'(q);
        if (bits >= 64'h7F800000) return {sgn, POS_INF[30:0]};
        return {sgn, bits[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        bit           s;
        logic [127:0] ma;
        logic [127:0] mb;
        int           ea;
        int           eb;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return DEF_NAN;
            return {s, POS_INF[30:0]};
        end
        if (is_zero(a) || is_zero(b)) return {s, 31'd0};
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        return fp_pack(s, ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        bit           sa;
        bit           sb;
        bit           st;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] mt;
        int           ea;
        int           eb;
        int           et;
        int           e;
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DEF_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        sa = a[31];
        sb = b[31];
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        if (ea < eb) begin
            st = sa; sa = sb; sb = st;
            mt = ma; ma = mb; mb = mt;
            et = ea; ea = eb; eb = et;
        end
        if (ea - eb > 60) begin
            mb = (mb != 0) ? 128'd1 : 128'd0;
            ma = ma << 60;
            e  = ea - 60;
        end else begin
            ma = ma << (ea - eb);
            e  = eb;
        end
        if (sa == sb) begin
            mt = ma + mb;
            st = sa;
        end else if (ma >= mb) begin
            mt = ma - mb;
            st = sa;
        end else begin
            mt = mb - ma;
            st = sb;
        end
        if (mt == 0) return {sa & sb, 31'd0};
        return fp_pack(st, e, mt);
    endfunction

    function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
        bit           s;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] q;
        int           ea;
        int           eb;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if (is_inf(a)) return is_inf(b) ? DEF_NAN : {s, POS_INF[30:0]};
        if (is_inf(b)) return {s, 31'd0};
        if (is_zero(b)) return is_zero(a) ? DEF_NAN : {s, POS_INF[30:0]};
        if (is_zero(a)) return {s, 31'd0};
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        q = (ma << 80) / mb;
        if ((ma << 80) % mb != 0) q[0] = 1'b1;
        return fp_pack(s, ea - 80 - eb, q);
    endfunction

    function automatic logic [127:0] int_root(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] b;
        res = 0;
        b   = 128'd1 << 126;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_sqrt(input logic [31:0] x);
        logic [127:0] m;
        logic [127:0] r;
        int           e;
        if (is_nan(x)) return x | QUIET_BIT;
        if (is_zero(x)) return x;
        if (x[31]) return SQRT_NAN;
        if (is_inf(x)) return x;
        fp_unpack(x, m, e);
        if (e % 2 != 0) begin
            m = m << 1;
            e = e - 1;
        end
        m = m << 60;
        e = e - 60;
        r = int_root(m);
        if (r * r != m) r[0] = 1'b1;
        return fp_pack(1'b0, e / 2, r);
    endfunction

    always @(posedge i_clk) begin
        t_res        want;
        logic [31:0] mean_sq;
        logic [31:0] root;
        if (!i_rst_n) begin
            eps       = EPS_RST;
            sum_sq    = '0;
            n_elems   = '0;
            scale     = ONE_BITS;
            want_q.delete();
            o_errors  = 0;
            o_pending = 0;
            o_items   = 0;
            o_results = 0;
            o_rows    = 0;
        end else begin
            if (i_cfg_we) eps = i_cfg_data;
            if (pop && !empty) begin
                o_results++;
                if (want_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result bits=%h end=%b", i_result_bits,
                                 i_result_end);
                    o_errors++;
                end else begin
                    want = want_q.pop_front();
                    if (want.bits !== i_result_bits || want.last !== i_result_end) begin
                        if (o_errors < 10)
                            $display("result mismatch: expected bits=%h end=%b, got bits=%h end=%b",
                                     want.bits, want.last, i_result_bits, i_result_end);
                        o_errors++;
                    end
                end
            end
            if (push && !full) begin
                o_items++;
                if (i_cmd == 1'b0) begin
                    sum_sq = fp_add(sum_sq, fp_mul(i_value_bits, i_value_bits));
                    if (n_elems != '1) n_elems = n_elems + 1'b1;
                    if (i_row_end) begin
                        o_rows++;
                        mean_sq = fp_div(sum_sq, fp_pack(1'b0, 0, 128'(n_elems)));
                        root    = fp_sqrt(fp_add(mean_sq, eps));
                        if (root[30:0] == 0)
                            scale = {root[31], POS_INF[30:0]};
                        else
                            scale = fp_div(ONE_BITS, root);
                        sum_sq  = '0;
                        n_elems = '0;
                    end
                end else begin
                    want.bits = fp_mul(fp_mul(i_value_bits, scale), i_weight_bits);
                    want.last = i_row_end;
                    want_q.push_back(want);
                end
            end
            o_pending = want_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top import rnsm_pkg::*; ;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 500;
    localparam int PHASE_ITEMS = 285;
    localparam int HOLD_AT    = 450;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        cmd;
    logic [31:0] value;
    logic [31:0] weight;
    logic        row_end;
    logic        empty;
    logic        pop;
    logic [31:0] res_bits;
    logic        res_end;
    logic        cfg_we;
    logic [31:0] cfg_data;

    int errors;
    int pending;
    int n_items;
    int n_results;
    int n_rows;
    int sent;
    int quiet_cycles;
    int hold_left;
    bit idle_on;
    bit held;

    logic [31:0] specials[11] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                                  32'h7FC00000, 32'h7F800001, 32'h00000001, 32'h807FFFFF,
                                  32'h7F7FFFFF, 32'h3F800000, 32'h00800000};
    logic [31:0] eps_set[6] = '{32'h00000000, 32'hFFFFFFFF, 32'hBF800000, 32'h7F7FFFFF,
                                32'h3C000000, EPS_RST};

    rms_norm_scale_multiply dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (cmd),
        .i_value_bits (value),
        .i_weight_bits(weight),
        .i_row_end    (row_end),
        .empty        (empty),
        .pop          (pop),
        .o_result_bits(res_bits),
        .o_result_end (res_end),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data)
    );

    rnsm_result_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (cmd),
        .i_value_bits (value),
        .i_weight_bits(weight),
        .i_row_end    (row_end),
        .empty        (empty),
        .pop          (pop),
        .i_result_bits(res_bits),
        .i_result_end (res_end),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_items      (n_items),
        .o_results    (n_results),
        .o_rows       (n_rows)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] pick_float();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return $urandom;
        if (sel < 40) return specials[$urandom_range(0, 10)];
        return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endfunction

    task automatic send(input logic c, input logic [31:0] v, input logic [31:0] w,
                        input logic last);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 25) begin
            push = 1'b0;
            @(negedge clk);
        end
        push    = 1'b1;
        cmd     = c;
        value   = v;
        weight  = w;
        row_end = last;
        sent++;
        do @(posedge clk); while (full);
    endtask

    task automatic drain_and_write(input logic [31:0] eps);
        @(negedge clk);
        push = 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = eps;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_rows(input int count);
        int stop;
        int len;
        stop = sent + count;
        while (sent < stop) begin
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) send(1'b0, pick_float(), $urandom, i == len - 1);
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send(1'b1, pick_float(), pick_float(), i == len - 1);
            end else begin
                send(1'($urandom), $urandom, $urandom, 1'($urandom));
            end
        end
    endtask

    // receiver side
    always @(negedge clk) begin
        if (!rst_n) begin
            pop = 1'b0;
        end else if (!held && sent >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = 400;
            pop       = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop = 1'b0;
        end else begin
            pop = !(idle_on && $urandom_range(0, 99) < 25);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        push         = 1'b0;
        cmd          = 1'b0;
        value        = '0;
        weight       = '0;
        row_end      = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        sent         = 0;
        idle_on      = 1'b1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send(1'b1, 32'h3F800000, 32'h40000000, 1'b0);
        send(1'b1, 32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1);
        send(1'b0, 32'h7F7FFFFF, 32'h0, 1'b1);
        send(1'b1, 32'h7F800000, 32'h3F800000, 1'b1);
        send(1'b1, 32'h3F800000, 32'h3F800000, 1'b1);
        send(1'b0, 32'h7FC00001, 32'h0, 1'b0);
        send(1'b0, 32'h3F800000, 32'h0, 1'b1);
        send(1'b1, 32'h7FA00000, 32'h7FC00123, 1'b1);
        send(1'b0, 32'h00000001, 32'h0, 1'b0);
        send(1'b0, 32'h80000001, 32'h0, 1'b1);
        send(1'b1, 32'h00000001, 32'h7F7FFFFF, 1'b0);
        send(1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b1);
        send(1'b0, 32'h3F800000, 32'h0, 1'b0);
        send(1'b0, 32'hC0000000, 32'h0, 1'b0);
        send(1'b0, 32'h40400000, 32'h0, 1'b1);
        send(1'b1, 32'h80000000, 32'hFF800000, 1'b0);
        send(1'b1, 32'h3F800000, 32'h3F800000, 1'b0);
        send(1'b1, 32'h807FFFFF, 32'hC0000000, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(eps_set[ph]);
            send(1'b0, 32'h00000000, 32'h0, 1'b1);
            send(1'b1, 32'h3F800000, 32'h3F800000, 1'b1);
            idle_on = (ph != 2);
            random_rows(PHASE_ITEMS);
            idle_on = 1'b1;
        end
        @(negedge clk);
        push = 1'b0;

        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d input transfers and %0d result transfers, %0d rows scaled",
                 n_items, n_results, n_rows);
        $display("six epsilon settings including zero, nan, negative and max finite");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
